### hdl/pulse_period_to_speed_rpm_defines.svh
// Assertion macros shared by the tachometer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PULSE_PERIOD_TO_SPEED_RPM_DEFINES_SVH
`define PULSE_PERIOD_TO_SPEED_RPM_DEFINES_SVH

// Check a property on every clock edge outside reset
`define PPSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle
`define PPSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ppsr_pkg.sv
// Types and constants for the pulse-period tachometer.
// No dependencies; used by pulse_period_to_speed_rpm.
package ppsr_pkg;

  // Timer and conversion constants
  localparam int unsigned TICK_HZ       = 307200;
  localparam int unsigned SPEED_NUM     = TICK_HZ * 3600;
  localparam int unsigned RPM_NUM       = TICK_HZ * 60;
  localparam int unsigned SPEED_TIMEOUT = 6;
  localparam int unsigned RPM_TIMEOUT   = 3;

  // Significant bits of the captured period
  localparam int unsigned PERIOD_WIDTH = 32;
  localparam logic [31:0] PERIOD_MASK  = 32'((64'd1 << PERIOD_WIDTH) - 64'd1);

  // Serial datapath sizes
  localparam int unsigned PROD_W    = 40;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned DIST_BITS = 16;
  localparam int unsigned PPR_BITS  = 8;
  localparam int unsigned QUOT_BITS = 32;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PPR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_PPR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_LIM    = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_SPEED = 2'd1,
    MODE_TACHO = 2'd2,
    MODE_FREQ  = 2'd3
  } mode_e;

  // What a finished item does to the stored values
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_SPEED_ZERO,
    OP_RPM_ZERO,
    OP_SPEED_CALC,
    OP_RPM_CALC
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DIST,
    ST_MUL_PPR,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic        command;
    logic [31:0] period_count;
    logic [7:0]  overflow_count;
  } ppsr_in_t;

  typedef struct packed {
    logic [15:0] speed_kmh;
    logic [15:0] engine_rpm;
  } ppsr_out_t;

endpackage

### hdl/pulse_period_to_speed_rpm.sv
// Pulse-period tachometer: turns a captured period into km/h or rpm.
// Depends on ppsr_pkg and pulse_period_to_speed_rpm_defines.svh.
//
// Each accepted item yields exactly one result holding the current speed and
// rpm. A speed capture forms period times wheel distance, then times pulses
// per rev, then the quotient, stores the result and returns to idle to take
// the next item; a tacho capture skips the first product, and an item without
// a capture command or any item in mode none or frequency goes straight to
// the store. The multiplier is a one-bit-per-cycle shift-and-add and the
// restoring divider yields one quotient bit per cycle. A new item is taken
// as soon as the previous one is stored, even while its result still waits
// in the output register; an item is stored only once that register is free.
// There is no clearing pass after reset.
`include "pulse_period_to_speed_rpm_defines.svh"

module pulse_period_to_speed_rpm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ppsr_pkg::ppsr_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ppsr_pkg::ppsr_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ppsr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppsr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import ppsr_pkg::*;

  // Configuration registers
  mode_e       mode_q;
  logic [15:0] wheel_dist_q;
  logic [7:0]  speed_ppr_q;
  logic [7:0]  engine_ppr_q;
  logic [15:0] speed_lim_q;
  logic [15:0] rpm_lim_q;

  // Control
  state_e             state_q, state_d;
  op_e                op_q, op_d, op_sel;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               in_accept, out_load;

  // Serial datapath
  logic [PROD_W-1:0]    mcand_q, mcand_d;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [DIST_BITS-1:0] mplier_q, mplier_d;
  logic [PROD_W-1:0]    rem_q, rem_d;
  logic [QUOT_BITS-1:0] num_q, num_d;
  logic [PROD_W-1:0]    mul_sum;
  logic [PROD_W:0]      div_shift;
  logic [PROD_W+1:0]    div_diff;
  logic                 div_ge;
  logic [31:0]          period;

  // Stored values and output register
  logic [15:0] speed_q, speed_d;
  logic [15:0] rpm_q, rpm_d;
  ppsr_out_t   out_q, out_d;
  logic [15:0] speed_calc, rpm_calc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign period = in_data_i.period_count & PERIOD_MASK;

  // One multiplier bit and one quotient bit per cycle
  assign mul_sum   = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign div_shift = {rem_q, num_q[QUOT_BITS-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, acc_q};
  assign div_ge    = !div_diff[PROD_W+1];

  // Clamp the quotient to the configured ceilings
  assign speed_calc = (num_q > {16'h0000, speed_lim_q}) ? speed_lim_q : num_q[15:0];
  assign rpm_calc   = (num_q > {16'h0000, rpm_lim_q}) ? rpm_lim_q : num_q[15:0];

  // Decide what the item does
  always_comb begin
    op_sel = OP_HOLD;
    unique case (mode_q)
      MODE_NONE: op_sel = OP_CLEAR;
      MODE_SPEED: begin
        if (in_data_i.command) begin
          op_sel = OP_SPEED_CALC;
        end else if (in_data_i.overflow_count >= 8'(SPEED_TIMEOUT)) begin
          op_sel = OP_SPEED_ZERO;
        end
      end
      MODE_TACHO: begin
        if (in_data_i.command) begin
          op_sel = OP_RPM_CALC;
        end else if (in_data_i.overflow_count >= 8'(RPM_TIMEOUT)) begin
          op_sel = OP_RPM_ZERO;
        end
      end
      MODE_FREQ: op_sel = OP_HOLD;
      default: op_sel = OP_HOLD;
    endcase
  end

  // Next state and datapath
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    num_d    = num_q;
    speed_d  = speed_q;
    rpm_d    = rpm_q;
    out_d    = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d    = op_sel;
          mcand_d = {8'h00, period};
          acc_d   = '0;
          if (op_sel == OP_SPEED_CALC) begin
            mplier_d = wheel_dist_q;
            cnt_d    = CNT_W'(DIST_BITS - 1);
            state_d  = ST_MUL_DIST;
          end else if (op_sel == OP_RPM_CALC) begin
            mplier_d = {8'h00, engine_ppr_q};
            cnt_d    = CNT_W'(PPR_BITS - 1);
            state_d  = ST_MUL_PPR;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_MUL_DIST: begin
        acc_d    = mul_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          // Keep the product modulo 2^32, then scale by pulses per rev
          mcand_d  = {8'h00, mul_sum[31:0]};
          acc_d    = '0;
          mplier_d = {8'h00, speed_ppr_q};
          cnt_d    = CNT_W'(PPR_BITS - 1);
          state_d  = ST_MUL_PPR;
        end
      end
      ST_MUL_PPR: begin
        acc_d    = mul_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d   = '0;
          num_d   = (op_q == OP_SPEED_CALC) ? 32'(SPEED_NUM) : 32'(RPM_NUM);
          cnt_d   = CNT_W'(QUOT_BITS - 1);
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        rem_d = div_ge ? div_diff[PROD_W-1:0] : div_shift[PROD_W-1:0];
        num_d = {num_q[QUOT_BITS-2:0], div_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          // Apply the item, a zero divisor leaves the value alone
          case (op_q)
            OP_CLEAR: begin
              speed_d = '0;
              rpm_d   = '0;
            end
            OP_SPEED_ZERO: speed_d = '0;
            OP_RPM_ZERO:   rpm_d = '0;
            OP_SPEED_CALC: begin
              if (acc_q != '0) begin
                speed_d = speed_calc;
              end
            end
            OP_RPM_CALC: begin
              if (acc_q != '0) begin
                rpm_d = rpm_calc;
              end
            end
            default: ;
          endcase
          out_d.speed_kmh  = speed_d;
          out_d.engine_rpm = rpm_d;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Hold the result until taken
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_HOLD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      speed_q     <= '0;
      rpm_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      speed_q     <= speed_d;
      rpm_q       <= rpm_d;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    num_q    <= num_d;
    out_q    <= out_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NONE;
      wheel_dist_q <= 16'd1;
      speed_ppr_q  <= 8'd1;
      engine_ppr_q <= 8'd1;
      speed_lim_q  <= 16'd400;
      rpm_lim_q    <= 16'd20000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:       mode_q <= mode_e'(cfg_wdata_i[1:0]);
        CFG_WHEEL_DIST: wheel_dist_q <= cfg_wdata_i;
        CFG_SPEED_PPR:  speed_ppr_q <= cfg_wdata_i[7:0];
        CFG_ENGINE_PPR: engine_ppr_q <= cfg_wdata_i[7:0];
        CFG_SPEED_LIM:  speed_lim_q <= cfg_wdata_i;
        CFG_RPM_LIM:    rpm_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Checks
  `PPSR_ASSERT_NEXT(a_accept_busy, in_accept, state_q != ST_IDLE, "accepted item did not start")
  `PPSR_ASSERT(a_valid_from_finish, $rose(out_valid_o) |-> $past(state_q == ST_FINISH), "result without finish")
  `PPSR_ASSERT_NEXT(a_div_done, state_q == ST_DIVIDE && cnt_q == '0, state_q == ST_FINISH, "divider overran")
  `PPSR_ASSERT_NEXT(a_clear_zero, out_load && op_q == OP_CLEAR, out_valid_q && out_q == '0, "mode none not zeroed")

endmodule

### test/pulse_period_to_speed_rpm_test.sv
// Self-checking bench for pulse_period_to_speed_rpm: directed and random items
// are scored against a behavioral tachometer kept inside this module.
// Depends on ppsr_pkg and the pulse_period_to_speed_rpm RTL.
module pulse_period_to_speed_rpm_test;
  import ppsr_pkg::*;

  // Conversion constants: 307200 Hz ticks scaled to km/h and rpm
  localparam logic [31:0] SPEED_DIVIDEND  = 32'd1105920000;
  localparam logic [31:0] RPM_DIVIDEND    = 32'd18432000;
  localparam logic [7:0]  SPEED_OVF_LIMIT = 8'd6;
  localparam logic [7:0]  RPM_OVF_LIMIT   = 8'd3;
  localparam int          RANDOM_PHASES   = 12;
  localparam int          PHASE_ITEMS     = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  ppsr_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ppsr_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Mirror of the register file and the stored values
  mode_e       cfg_mode   = MODE_NONE;
  logic [15:0] wheel_dist = 16'd1;
  logic [7:0]  speed_ppr  = 8'd1;
  logic [7:0]  engine_ppr = 8'd1;
  logic [15:0] speed_lim  = 16'd400;
  logic [15:0] rpm_lim    = 16'd20000;
  logic [15:0] speed_val  = '0;
  logic [15:0] rpm_val    = '0;

  ppsr_out_t expected_readings[$];
  int        src_idle_pct   = 33;
  int        sink_stall_pct = 59;
  int        items_sent       = 0;
  int        readings_checked = 0;
  int        settings_applied = 0;
  int        mismatches       = 0;

  pulse_period_to_speed_rpm u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the stored speed and rpm by one item, return the reading
  function automatic ppsr_out_t predict_readout(input ppsr_in_t it);
    logic [31:0] prod;
    logic [31:0] quot;
    ppsr_out_t   r;
    case (cfg_mode)
      MODE_NONE: begin
        speed_val = '0;
        rpm_val   = '0;
      end
      MODE_SPEED: begin
        if (it.command) begin
          // Product wraps at 32 bits; a zero divisor keeps the old value
          prod = it.period_count * {16'd0, wheel_dist};
          if (prod != 32'd0 && speed_ppr != 8'd0) begin
            quot = SPEED_DIVIDEND / prod / {24'd0, speed_ppr};
            speed_val = (quot > {16'd0, speed_lim}) ? speed_lim : quot[15:0];
          end
        end else if (it.overflow_count >= SPEED_OVF_LIMIT) begin
          speed_val = '0;
        end
      end
      MODE_TACHO: begin
        if (it.command) begin
          if (it.period_count != 32'd0 && engine_ppr != 8'd0) begin
            quot = RPM_DIVIDEND / it.period_count / {24'd0, engine_ppr};
            rpm_val = (quot > {16'd0, rpm_lim}) ? rpm_lim : quot[15:0];
          end
        end else if (it.overflow_count >= RPM_OVF_LIMIT) begin
          rpm_val = '0;
        end
      end
      default: begin
        // frequency mode holds both values
      end
    endcase
    r.speed_kmh  = speed_val;
    r.engine_rpm = rpm_val;
    return r;
  endfunction

  // Offer one item after a random gap, hold it until taken, then predict
  task automatic send_item(input logic cmd, input logic [31:0] period,
                           input logic [7:0] ovf);
    ppsr_in_t it;
    it.command        = cmd;
    it.period_count   = period;
    it.overflow_count = ovf;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_readings.push_back(predict_readout(it));
    items_sent++;
  endtask

  // Drop valid and wait until every reading has come back
  task automatic wait_settled(input int extra_cycles);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      CFG_MODE:       cfg_mode   = mode_e'(d[1:0]);
      CFG_WHEEL_DIST: wheel_dist = d;
      CFG_SPEED_PPR:  speed_ppr  = d[7:0];
      CFG_ENGINE_PPR: engine_ppr = d[7:0];
      CFG_SPEED_LIM:  speed_lim  = d;
      CFG_RPM_LIM:    rpm_lim    = d;
      default: begin
      end
    endcase
  endtask

  // Rewrite all six registers once the block is idle
  task automatic apply_settings(input mode_e m, input logic [15:0] wdist,
                                input logic [7:0] sppr, input logic [7:0] eppr,
                                input logic [15:0] slim, input logic [15:0] rlim);
    wait_settled(4);
    write_reg(CFG_MODE, 16'(m));
    write_reg(CFG_WHEEL_DIST, wdist);
    write_reg(CFG_SPEED_PPR, {8'd0, sppr});
    write_reg(CFG_ENGINE_PPR, {8'd0, eppr});
    write_reg(CFG_SPEED_LIM, slim);
    write_reg(CFG_RPM_LIM, rlim);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Score each accepted reading and toggle the output stall
  always @(posedge clk) begin
    ppsr_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none, actual speed_kmh=%0d engine_rpm=%0d",
                   $time, out_data.speed_kmh, out_data.engine_rpm);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (out_data.speed_kmh !== want.speed_kmh) begin
            $display("%0t: speed_kmh expected %0d actual %0d",
                     $time, want.speed_kmh, out_data.speed_kmh);
            mismatches++;
          end
          if (out_data.engine_rpm !== want.engine_rpm) begin
            $display("%0t: engine_rpm expected %0d actual %0d",
                     $time, want.engine_rpm, out_data.engine_rpm);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Both values read zero out of reset in mode none
  task automatic test_reset_state();
    send_item(1'b0, 32'd0, 8'd0);
    send_item(1'b1, 32'd1, 8'd0);
  endtask

  // Speed captures: saturation, zero period, timeout boundary
  task automatic test_speed_conversion();
    apply_settings(MODE_SPEED, 16'd1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 32'd1, 8'd0);
    send_item(1'b1, 32'hFFFF_FFFF, 8'd0);
    send_item(1'b1, 32'd16875, 8'd0);
    send_item(1'b1, 32'd0, 8'd0);
    send_item(1'b1, 32'd307200, 8'hFF);
    send_item(1'b0, 32'd0, 8'd5);
    send_item(1'b0, 32'hFFFF_FFFF, 8'd6);
    send_item(1'b1, 32'd307200, 8'd0);
  endtask

  // Tacho captures while the speed value stays held
  task automatic test_tacho_conversion();
    apply_settings(MODE_TACHO, 16'd1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 32'd1, 8'd0);
    send_item(1'b1, 32'd0, 8'd0);
    send_item(1'b1, 32'hFFFF_FFFF, 8'd0);
    send_item(1'b1, 32'd9216, 8'd0);
    send_item(1'b0, 32'd0, 8'd2);
    send_item(1'b0, 32'd0, 8'd3);
    send_item(1'b1, 32'd9216, 8'd255);
  endtask

  // Frequency mode holds everything, mode none clears everything
  task automatic test_none_and_freq();
    apply_settings(MODE_FREQ, 16'd1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 32'd1, 8'd0);
    send_item(1'b0, 32'd0, 8'd255);
    apply_settings(MODE_NONE, 16'd1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 32'd9216, 8'd0);
  endtask

  // Zero divisors hold the value; low limits clamp
  task automatic test_zero_divisors();
    apply_settings(MODE_SPEED, 16'd2, 8'd1, 8'd1, 16'd500, 16'd100);
    send_item(1'b1, 32'd1000, 8'd0);
    send_item(1'b1, 32'h8000_0000, 8'd0);
    apply_settings(MODE_SPEED, 16'd0, 8'd255, 8'd255, 16'd500, 16'd100);
    send_item(1'b1, 32'd1000, 8'd0);
    apply_settings(MODE_SPEED, 16'hFFFF, 8'd0, 8'd1, 16'd500, 16'd100);
    send_item(1'b1, 32'd1000, 8'd0);
    apply_settings(MODE_TACHO, 16'd1, 8'd1, 8'd1, 16'd500, 16'd100);
    send_item(1'b1, 32'd1000, 8'd0);
    apply_settings(MODE_TACHO, 16'd1, 8'd1, 8'd0, 16'd500, 16'd0);
    send_item(1'b1, 32'd1000, 8'd0);
    apply_settings(MODE_SPEED, 16'd1, 8'd255, 8'd1, 16'd0, 16'd0);
    send_item(1'b1, 32'd1, 8'd0);
  endtask

  // Random settings per phase, mostly captures with periods of every magnitude
  task automatic test_random_traffic();
    mode_e       m;
    logic [15:0] wdist;
    logic [7:0]  sppr;
    logic [7:0]  eppr;
    logic [15:0] slim;
    logic [15:0] rlim;
    int          pick;
    logic        cmd;
    logic [31:0] period;
    logic [7:0]  ovf;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph / 4)
        0: begin
          src_idle_pct   = 33;
          sink_stall_pct = 59;
        end
        1: begin
          src_idle_pct   = 59;
          sink_stall_pct = 33;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      pick = $urandom_range(9);
      m = (pick == 0) ? MODE_NONE : (pick == 1) ? MODE_FREQ :
          (pick < 6) ? MODE_SPEED : MODE_TACHO;
      case ($urandom_range(3))
        0:       wdist = 16'($urandom_range(1, 4));
        1:       wdist = 16'($urandom_range(1, 200));
        2:       wdist = 16'($urandom_range(65535));
        default: wdist = ($urandom_range(1) != 0) ? 16'hFFFF : 16'd0;
      endcase
      sppr = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      eppr = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      slim = ($urandom_range(1) != 0) ? 16'hFFFF : 16'($urandom_range(65535));
      rlim = ($urandom_range(1) != 0) ? 16'hFFFF : 16'($urandom_range(65535));
      // first phase pins speed mode and the top of wheel distance and both pulse counts
      if (ph == 0) begin
        m     = MODE_SPEED;
        wdist = 16'hFFFF;
        sppr  = 8'hFF;
        eppr  = 8'hFF;
      end
      apply_settings(m, wdist, sppr, eppr, slim, rlim);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd    = ($urandom_range(99) < 70);
        period = $urandom >> $urandom_range(31);
        ovf    = ($urandom_range(1) != 0) ? 8'($urandom_range(8)) : 8'($urandom_range(255));
        send_item(cmd, period, ovf);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_speed_conversion();
    test_tacho_conversion();
    test_none_and_freq();
    test_zero_divisors();
    test_random_traffic();
    wait_settled(80);
    $display("Sent %0d items (directed and random) across %0d register settings,",
             items_sent, settings_applied);
    $display("scored %0d readings with %0d mismatches.", readings_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Bound the run well past the slowest legal traffic
  initial begin
    #12000000;
    $display("%0t: timeout with %0d readings outstanding", $time, expected_readings.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
